[design/sj2u_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sj2u_pkg;

  localparam int unsigned MAX_OUT   = 1024;
  localparam logic [9:0]  CAP_RESET = 10'd128;
  localparam int unsigned NRES      = 4;

  typedef struct packed {
    logic [9:0] out_index;
    logic [7:0] out_byte;
    logic       is_terminator;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [2:0]         cnt;
    result_t [NRES-1:0] ent;
  } bundle_t;

  typedef struct packed {
    logic [7:0] held_lead;
    logic       lead_waiting;
    logic [9:0] written_count;
    logic [9:0] kept_length;
    logic       finished;
  } state_t;

endpackage

`default_nettype wire

[design/sj2u_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface sj2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;
  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface sj2u_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] out_index;
  logic [7:0] out_byte;
  logic       is_terminator;
  logic       run_last;
  modport source (output valid, output out_index, output out_byte,
                  output is_terminator, output run_last, input ready);
  modport sink (input valid, input out_index, input out_byte,
                input is_terminator, input run_last, output ready);
endinterface

interface sj2u_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] out_capacity;
  modport source (output valid, output out_capacity, input ready);
  modport sink (input valid, input out_capacity, output ready);
endinterface

`default_nettype wire

[design/sj2u_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

module sj2u_decode (
  input  sj2u_pkg::state_t  st,
  input  logic [7:0]        in_byte,
  input  logic              last_byte,
  input  logic [9:0]        out_capacity,
  output sj2u_pkg::bundle_t bundle,
  output sj2u_pkg::state_t  st_nxt
);

  localparam logic [15:0] CP_QMARK = 16'h003f;
  localparam logic [15:0] CP_YEN   = 16'h00a5;
  localparam logic [15:0] CP_HWKANA = 16'hff61;
  localparam logic [15:0] CP_IDSP  = 16'h3000;
  localparam logic [15:0] CP_CHOON = 16'h30fc;
  localparam logic [15:0] CP_WAVE  = 16'h301c;
  localparam logic [15:0] CP_FWDIG = 16'hff10;
  localparam logic [15:0] CP_FWUC  = 16'hff21;
  localparam logic [15:0] CP_FWLC  = 16'hff41;
  localparam logic [15:0] CP_HIRA  = 16'h3041;
  localparam logic [15:0] CP_KATA  = 16'h30a1;
  localparam logic [15:0] CP_KATA2 = 16'h30e0;
  localparam logic [12:0] MAX_CAP  = 13'(sj2u_pkg::MAX_OUT);

  function automatic logic [15:0] map_code(input logic [15:0] c);
    logic [15:0] r;
    r = CP_QMARK;
    if (c >= 16'h0020 && c <= 16'h007e) r = (c == 16'h005c) ? CP_YEN : c;
    else if (c >= 16'h00a1 && c <= 16'h00df) r = CP_HWKANA + (c - 16'h00a1);
    else if (c == 16'h8140) r = CP_IDSP;
    else if (c == 16'h8141) r = CP_IDSP + 16'd1;
    else if (c == 16'h8142) r = CP_IDSP + 16'd2;
    else if (c == 16'h815b) r = CP_CHOON;
    else if (c == 16'h8160) r = CP_WAVE;
    else if (c >= 16'h824f && c <= 16'h8258) r = CP_FWDIG + (c - 16'h824f);
    else if (c >= 16'h8260 && c <= 16'h8279) r = CP_FWUC + (c - 16'h8260);
    else if (c >= 16'h8281 && c <= 16'h829a) r = CP_FWLC + (c - 16'h8281);
    else if (c >= 16'h829f && c <= 16'h82f1) r = CP_HIRA + (c - 16'h829f);
    else if (c >= 16'h8340 && c <= 16'h837e) r = CP_KATA + (c - 16'h8340);
    else if (c >= 16'h8380 && c <= 16'h8396) r = CP_KATA2 + (c - 16'h8380);
    return r;
  endfunction

  logic [12:0] cap_eff;
  logic        full;
  logic        is_lead;
  logic [15:0] code;
  logic [15:0] cp;
  logic [1:0]  ulen;
  logic [1:0]  nemit;
  logic        str_end;
  logic [7:0]  u [4];
  logic [9:0]  wc_after;
  logic [9:0]  kept_after;
  logic [2:0]  cnt;

  always_comb begin
    cap_eff = ({3'b000, out_capacity} < MAX_CAP) ? {3'b000, out_capacity} : MAX_CAP;
    full    = ({3'b000, st.written_count} + 13'd4) >= cap_eff;
    is_lead = (in_byte >= 8'h81 && in_byte <= 8'h9f) ||
              (in_byte >= 8'he0 && in_byte <= 8'hef);
    code    = st.lead_waiting ? {st.held_lead, in_byte} : {8'h00, in_byte};
    cp      = map_code(code);

    if (cp < 16'h0080) ulen = 2'd1;
    else if (cp < 16'h0800) ulen = 2'd2;
    else ulen = 2'd3;

    if (ulen == 2'd1) u[0] = cp[7:0];
    else if (ulen == 2'd2) u[0] = {3'b110, cp[10:6]};
    else u[0] = {4'b1110, cp[15:12]};
    u[1] = (ulen == 2'd2) ? {2'b10, cp[5:0]} : {2'b10, cp[11:6]};
    u[2] = {2'b10, cp[5:0]};
    u[3] = 8'h00;

    st_nxt  = st;
    nemit   = 2'd0;
    str_end = 1'b0;
    if (st.finished) begin
      if (last_byte) st_nxt = '0;
    end else if (st.lead_waiting) begin
      nemit                 = ulen;
      str_end               = last_byte;
      st_nxt.lead_waiting   = 1'b0;
      st_nxt.held_lead      = 8'h00;
    end else if (full || in_byte == 8'h00) begin
      str_end = 1'b1;
    end else if (is_lead) begin
      if (last_byte) begin
        str_end = 1'b1;
      end else begin
        st_nxt.held_lead    = in_byte;
        st_nxt.lead_waiting = 1'b1;
      end
    end else begin
      nemit   = ulen;
      str_end = last_byte;
    end

    wc_after   = st.written_count + {8'h00, nemit};
    kept_after = st.kept_length;
    if (nemit != 2'd0 && !(nemit == 2'd1 && u[0] == 8'h20)) kept_after = wc_after;

    if (!st.finished) begin
      st_nxt.written_count = wc_after;
      st_nxt.kept_length   = kept_after;
      if (str_end) begin
        if (last_byte) st_nxt = '0;
        else st_nxt.finished = 1'b1;
      end
    end

    cnt = {1'b0, nemit} + {2'b00, str_end};
    bundle.cnt = cnt;
    for (int i = 0; i < 4; i++) begin
      bundle.ent[i] = '0;
      if (3'(i) < {1'b0, nemit}) begin
        bundle.ent[i].out_index = st.written_count + 10'(i);
        bundle.ent[i].out_byte  = u[i];
      end else if (3'(i) == {1'b0, nemit}) begin
        bundle.ent[i].out_index     = kept_after;
        bundle.ent[i].is_terminator = 1'b1;
      end
      bundle.ent[i].run_last = (3'(i) + 3'd1 == cnt);
    end
  end

endmodule

`default_nettype wire

[design/sj2u_out_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module sj2u_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sj2u_pkg::bundle_t bundle,
  output logic              can_load,
  sj2u_out_if.source        out_ch
);

  logic [2:0]                                 cnt_r;
  logic [2:0]                                 cnt_nxt;
  sj2u_pkg::result_t [sj2u_pkg::NRES-1:0]     ent_r;
  sj2u_pkg::result_t [sj2u_pkg::NRES-1:0]     ent_nxt;
  logic                                       pop;

  assign pop      = (cnt_r != 3'd0) && out_ch.ready;
  assign can_load = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ch.ready);

  assign out_ch.valid         = (cnt_r != 3'd0);
  assign out_ch.out_index     = ent_r[0].out_index;
  assign out_ch.out_byte      = ent_r[0].out_byte;
  assign out_ch.is_terminator = ent_r[0].is_terminator;
  assign out_ch.run_last      = ent_r[0].run_last;

  always_comb begin
    cnt_nxt = cnt_r;
    ent_nxt = ent_r;
    if (pop) begin
      cnt_nxt = cnt_r - 3'd1;
      for (int i = 0; i < sj2u_pkg::NRES - 1; i++) ent_nxt[i] = ent_r[i+1];
      ent_nxt[sj2u_pkg::NRES-1] = '0;
    end
    if (load) begin
      cnt_nxt = bundle.cnt;
      ent_nxt = bundle.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

[design/shift_jis_to_utf8_transcoder_core.sv]
// An accepted byte is registered, decoded and then loaded into the result queue.
// Throughput: one input byte per cycle while each byte yields at most one result
//   and the result channel is ready; a byte with more results holds the input.
// Result serialising queue of four entries sets the output pace.
// Reset (rst_n, synchronous): string state cleared, capacity set to 128.
`timescale 1ns / 1ps
`default_nettype none

module shift_jis_to_utf8_transcoder_core (
  input  logic        clk,
  input  logic        rst_n,
  sj2u_in_if.sink     in_ch,
  sj2u_out_if.source  out_ch,
  sj2u_cfg_if.sink    cfg_ch
);

  logic              in_v_r;
  logic [7:0]        in_byte_r;
  logic              in_last_r;
  logic [9:0]        cap_r;
  sj2u_pkg::state_t  st_r;
  sj2u_pkg::state_t  st_nxt;
  sj2u_pkg::bundle_t bundle;
  logic              can_load;
  logic              advance;
  logic              load;

  assign advance      = in_v_r && (bundle.cnt == 3'd0 || can_load);
  assign load         = advance && (bundle.cnt != 3'd0);
  assign in_ch.ready  = !in_v_r || advance;
  assign cfg_ch.ready = 1'b1;

  sj2u_decode u_decode (
    .st           (st_r),
    .in_byte      (in_byte_r),
    .last_byte    (in_last_r),
    .out_capacity (cap_r),
    .bundle       (bundle),
    .st_nxt       (st_nxt)
  );

  sj2u_out_queue u_out_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .bundle   (bundle),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      st_r   <= '0;
      cap_r  <= sj2u_pkg::CAP_RESET;
    end else begin
      if (in_ch.valid && in_ch.ready) in_v_r <= 1'b1;
      else if (advance) in_v_r <= 1'b0;
      if (advance) st_r <= st_nxt;
      if (cfg_ch.valid) cap_r <= cfg_ch.out_capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.in_byte;
      in_last_r <= in_ch.last_byte;
    end
  end

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam logic [15:0] QMARK_CP      = 16'h003f;
  localparam logic [15:0] BACKSLASH     = 16'h005c;
  localparam logic [15:0] YEN_CP        = 16'h00a5;
  localparam logic [15:0] HALF_KANA_CP  = 16'hff61;
  localparam logic [15:0] IDEO_SPACE_CP = 16'h3000;
  localparam logic [15:0] SJ_IDEO_SPACE = 16'h8140;
  localparam logic [15:0] LONG_MARK_CP  = 16'h30fc;
  localparam logic [15:0] WAVE_DASH_CP  = 16'h301c;
  localparam logic [15:0] FW_DIGIT_CP   = 16'hff10;
  localparam logic [15:0] FW_UPPER_CP   = 16'hff21;
  localparam logic [15:0] FW_LOWER_CP   = 16'hff41;
  localparam logic [15:0] HIRAGANA_CP   = 16'h3041;
  localparam logic [15:0] KATAKANA_CP   = 16'h30a1;
  localparam logic [15:0] KATAKANA2_CP  = 16'h30e0;
  localparam logic [7:0]  ASCII_SPACE   = 8'h20;
  localparam logic [7:0]  NUL_BYTE      = 8'h00;
  localparam int          IDLE_PCT      = 17;
  localparam logic [7:0]  PUNCT_TRAIL [5] = '{8'h40, 8'h41, 8'h42, 8'h5b, 8'h60};

  typedef struct {
    logic [7:0]        code;
    logic              last;
    bit                typed;
    sj2u_pkg::result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  sj2u_in_if  in_ch ();
  sj2u_out_if out_ch ();
  sj2u_cfg_if cfg_ch ();

  shift_jis_to_utf8_transcoder_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // predictor state
  logic [9:0] capacity_setting;
  logic [7:0] lead_held;
  logic       lead_pending;
  logic [9:0] utf8_count;
  logic [9:0] trimmed_len;
  logic       string_done;

  sj2u_pkg::result_t predicted_utf8 [$];
  sj2u_pkg::result_t pending_utf8 [$];
  logic [7:0]        str_bytes [$];
  int                mismatches;
  int                sent_bytes;
  bit                steady;

  function automatic logic [15:0] sjis_to_ucs(input logic [15:0] c);
    if (c >= 16'h0020 && c <= 16'h007e) return (c == BACKSLASH) ? YEN_CP : c;
    if (c >= 16'h00a1 && c <= 16'h00df) return HALF_KANA_CP + (c - 16'h00a1);
    if (c == SJ_IDEO_SPACE) return IDEO_SPACE_CP;
    if (c == 16'h8141) return IDEO_SPACE_CP + 16'd1;
    if (c == 16'h8142) return IDEO_SPACE_CP + 16'd2;
    if (c == 16'h815b) return LONG_MARK_CP;
    if (c == 16'h8160) return WAVE_DASH_CP;
    if (c >= 16'h824f && c <= 16'h8258) return FW_DIGIT_CP + (c - 16'h824f);
    if (c >= 16'h8260 && c <= 16'h8279) return FW_UPPER_CP + (c - 16'h8260);
    if (c >= 16'h8281 && c <= 16'h829a) return FW_LOWER_CP + (c - 16'h8281);
    if (c >= 16'h829f && c <= 16'h82f1) return HIRAGANA_CP + (c - 16'h829f);
    if (c >= 16'h8340 && c <= 16'h837e) return KATAKANA_CP + (c - 16'h8340);
    if (c >= 16'h8380 && c <= 16'h8396) return KATAKANA2_CP + (c - 16'h8380);
    return QMARK_CP;
  endfunction

  function automatic bit is_lead(input logic [7:0] b);
    return (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hef);
  endfunction

  task automatic clear_string();
    lead_held    = 8'h00;
    lead_pending = 1'b0;
    utf8_count   = 10'd0;
    trimmed_len  = 10'd0;
    string_done  = 1'b0;
  endtask

  task automatic emit_utf8_byte(input logic [7:0] ub);
    sj2u_pkg::result_t r;
    r = '{out_index: utf8_count, out_byte: ub, is_terminator: 1'b0, run_last: 1'b0};
    predicted_utf8 = {predicted_utf8, r};
    utf8_count = utf8_count + 10'd1;
    if (ub != ASCII_SPACE) trimmed_len = utf8_count;
  endtask

  task automatic emit_codepoint(input logic [15:0] cp);
    if (cp < 16'h0080) begin
      emit_utf8_byte(cp[7:0]);
    end else if (cp < 16'h0800) begin
      emit_utf8_byte({3'b110, cp[10:6]});
      emit_utf8_byte({2'b10, cp[5:0]});
    end else begin
      emit_utf8_byte({4'b1110, cp[15:12]});
      emit_utf8_byte({2'b10, cp[11:6]});
      emit_utf8_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic transcode_byte(input logic [7:0] b, input logic last);
    bit                ends;
    int                eff_cap;
    sj2u_pkg::result_t term;
    ends = 1'b0;
    sent_bytes++;
    predicted_utf8.delete();
    eff_cap = (int'(capacity_setting) < sj2u_pkg::MAX_OUT) ? int'(capacity_setting)
                                                           : sj2u_pkg::MAX_OUT;
    if (string_done) begin
      if (last) clear_string();
    end else begin
      if (lead_pending) begin
        emit_codepoint(sjis_to_ucs({lead_held, b}));
        lead_pending = 1'b0;
        lead_held    = 8'h00;
        ends = last;
      end else if (int'(utf8_count) + 4 >= eff_cap || b == NUL_BYTE) begin
        ends = 1'b1;
      end else if (is_lead(b)) begin
        if (last) begin
          ends = 1'b1;
        end else begin
          lead_held    = b;
          lead_pending = 1'b1;
        end
      end else begin
        emit_codepoint(sjis_to_ucs({8'h00, b}));
        ends = last;
      end
      if (ends) begin
        term = '{out_index: trimmed_len, out_byte: NUL_BYTE, is_terminator: 1'b1,
                 run_last: 1'b0};
        predicted_utf8 = {predicted_utf8, term};
        if (last) clear_string();
        else string_done = 1'b1;
      end
      if (predicted_utf8.size() > 0)
        predicted_utf8[predicted_utf8.size()-1].run_last = 1'b1;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input sj2u_pkg::result_t typed_res);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    transcode_byte(b, last);
    if (typed) begin
      pending_utf8 = {pending_utf8, typed_res};
    end else begin
      foreach (predicted_utf8[i]) pending_utf8 = {pending_utf8, predicted_utf8[i]};
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_utf8.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [9:0] cap);
    drain_results();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.out_capacity <= cap;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    capacity_setting = cap;
  endtask

  task automatic add_char();
    int         pick;
    logic [7:0] lead;
    logic [7:0] trail;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      str_bytes = {str_bytes, 8'($urandom_range(8'h20, 8'h7e))};
    end else if (pick < 40) begin
      str_bytes = {str_bytes, ASCII_SPACE};
    end else if (pick < 50) begin
      str_bytes = {str_bytes, 8'($urandom_range(8'ha1, 8'hdf))};
    end else if (pick < 75) begin
      lead = 8'h82;
      case ($urandom_range(0, 5))
        0: begin
          lead  = 8'h81;
          trail = PUNCT_TRAIL[$urandom_range(0, 4)];
        end
        1: trail = 8'($urandom_range(8'h4f, 8'h58));
        2: trail = 8'($urandom_range(8'h60, 8'h79));
        3: trail = 8'($urandom_range(8'h81, 8'h9a));
        4: trail = 8'($urandom_range(8'h9f, 8'hf1));
        default: begin
          lead  = 8'h83;
          trail = 8'($urandom_range(8'h40, 8'h96));
        end
      endcase
      str_bytes = {str_bytes, lead, trail};
    end else if (pick < 85) begin
      lead = $urandom_range(0, 1) ? 8'($urandom_range(8'h81, 8'h9f))
                                  : 8'($urandom_range(8'he0, 8'hef));
      str_bytes = {str_bytes, lead, 8'($urandom_range(0, 255))};
    end else if (pick < 93) begin
      str_bytes = {str_bytes, 8'($urandom_range(0, 255))};
    end else begin
      str_bytes = {str_bytes, NUL_BYTE};
    end
  endtask

  task automatic send_string();
    int         n_chars;
    logic [7:0] tail;
    n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 10);
    str_bytes.delete();
    repeat (n_chars) add_char();
    // broken tail: a lone lead byte as the final byte
    if ($urandom_range(0, 99) < 8) begin
      tail = $urandom_range(0, 1) ? 8'($urandom_range(8'h81, 8'h9f))
                                  : 8'($urandom_range(8'he0, 8'hef));
      str_bytes = {str_bytes, tail};
    end
    foreach (str_bytes[i])
      send_byte(str_bytes[i], i == str_bytes.size() - 1, 1'b0, '0);
  endtask

  always @(posedge clk) begin : check_results
    sj2u_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_utf8.size() == 0) begin
        $error("unexpected transaction: index %0d byte %02h term %0b",
               out_ch.out_index, out_ch.out_byte, out_ch.is_terminator);
        mismatches++;
      end else begin
        want = pending_utf8.pop_front();
        if (out_ch.out_index !== want.out_index) begin
          $error("out_index: expected %0d, got %0d", want.out_index, out_ch.out_index);
          mismatches++;
        end
        if (out_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.is_terminator !== want.is_terminator) begin
          $error("is_terminator: expected %0b, got %0b", want.is_terminator,
                 out_ch.is_terminator);
          mismatches++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_ch.run_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    dir_row_t   directed_rows [25];
    logic [9:0] caps [9];
    int         phase_items;
    directed_rows = '{
      '{8'h41, 1'b0, 1'b1, '{10'd0, 8'h41, 1'b0, 1'b1}},
      '{8'h20, 1'b0, 1'b1, '{10'd1, 8'h20, 1'b0, 1'b1}},
      '{8'h5c, 1'b0, 1'b0, '0},
      '{8'ha1, 1'b0, 1'b0, '0},
      '{8'hdf, 1'b0, 1'b0, '0},
      '{8'h81, 1'b0, 1'b0, '0},
      '{8'h40, 1'b0, 1'b0, '0},
      '{8'h82, 1'b0, 1'b0, '0},
      '{8'h4f, 1'b0, 1'b0, '0},
      '{8'h83, 1'b0, 1'b0, '0},
      '{8'h96, 1'b0, 1'b0, '0},
      '{8'h88, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'he0, 1'b0, 1'b0, '0},
      '{8'hff, 1'b0, 1'b0, '0},
      '{8'h7f, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'hff, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h20, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h41, 1'b0, 1'b0, '0},
      '{8'h9f, 1'b1, 1'b0, '0},
      '{8'hef, 1'b1, 1'b1, '{10'd0, 8'h00, 1'b1, 1'b1}},
      '{8'h7e, 1'b1, 1'b0, '0}
    };
    caps = '{10'd1023, 10'd0, 10'd1, 10'd4, 10'd5, 10'd6, 10'd12,
             10'($urandom_range(13, 200)), sj2u_pkg::CAP_RESET};

    mismatches = 0;
    sent_bytes = 0;
    steady     = 1'b0;
    capacity_setting = sj2u_pkg::CAP_RESET;
    clear_string();

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.in_byte       <= 8'h00;
    in_ch.last_byte     <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.out_capacity <= 10'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].code, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].res);

    foreach (caps[p]) begin
      set_capacity(caps[p]);
      steady = (p == 0);
      phase_items = sent_bytes + ((p == 0) ? 20 : 10);
      while (sent_bytes < phase_items) send_string();
    end
    steady = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
